// ===== rtl/core/kth_smallest_select_defines.svh =====
// Assertion macros for the bound checker of the selection block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef KTH_SMALLEST_SELECT_DEFINES_SVH
`define KTH_SMALLEST_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/kss_pkg.sv =====
package kss_pkg;

	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 12;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RD_LO,
		S_RD_MID,
		S_RD_HI,
		S_MED1,
		S_MED2,
		S_PART,
		S_SCAN_E,
		S_SCAN_S,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MED_LO,
		MED_MID,
		MED_HI
	} med_sel_t;

	typedef struct packed {
		logic                       valid;
		logic signed [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0]        status;
	} result_t;

endpackage

// ===== rtl/core/kss_mem.sv =====
module kss_mem import kss_pkg::*; #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [VALUE_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic signed [VALUE_W-1:0] rdata
);

	logic signed [VALUE_W-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/kss_cmp.sv =====
module kss_cmp import kss_pkg::*; (
	input  logic signed [VALUE_W-1:0] lhs,
	input  logic signed [VALUE_W-1:0] rhs,
	output logic                      gt
);

	// Signed greater-than compare through one widened subtraction.
	logic signed [VALUE_W:0] diff;

	assign diff = {lhs[VALUE_W-1], lhs} - {rhs[VALUE_W-1], rhs};
	assign gt   = !diff[VALUE_W] && (diff != '0);

endmodule

// ===== rtl/core/kss_ctrl.sv =====
module kss_ctrl import kss_pkg::*; #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic signed [VALUE_W-1:0] item_value,
	input  logic                      item_last,
	output logic                      item_stall,
	input  logic [RANK_W-1:0]         rank,
	output result_t                   res,
	input  logic                      res_take,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic signed [VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]             mem_raddr,
	input  logic signed [VALUE_W-1:0] mem_rdata
);

	localparam int RW = (CW > RANK_W) ? CW : RANK_W;
	localparam int SW = (AW > RANK_W) ? AW : RANK_W;

	state_t                    state_q, state_d;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic                      ovf_q, ovf_d;
	logic [AW-1:0]             lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0]             s_q, s_d, e_q, e_d;
	logic [AW-1:0]             mid;
	logic signed [VALUE_W-1:0] piv_q, piv_d;
	logic signed [VALUE_W-1:0] a_q, a_d, m_q, m_d, b_q, b_d;
	logic                      x_q, x_d, y_q, y_d;
	logic signed [VALUE_W-1:0] res_val_q, res_val_d;
	logic [STATUS_W-1:0]       res_st_q, res_st_d;
	logic signed [VALUE_W-1:0] cmp_lhs, cmp_rhs;
	logic                      cmp_gt;
	logic                      full;
	logic                      round_end;
	med_sel_t                  med;

	kss_cmp u_cmp (
		.lhs (cmp_lhs),
		.rhs (cmp_rhs),
		.gt  (cmp_gt)
	);

	assign full = (cnt_q == CW'(DEPTH));
	assign mid  = lo_q + ((hi_q - lo_q) >> 1);

	assign res.valid  = (state_q == S_DONE);
	assign res.value  = res_val_q;
	assign res.status = res_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			s_q     <= '0;
			e_q     <= '0;
			piv_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			s_q     <= s_d;
			e_q     <= e_d;
			piv_q   <= piv_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q       <= a_d;
		m_q       <= m_d;
		b_q       <= b_d;
		x_q       <= x_d;
		y_q       <= y_d;
		res_val_q <= res_val_d;
		res_st_q  <= res_st_d;
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ovf_d      = ovf_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		s_d        = s_q;
		e_d        = e_q;
		piv_d      = piv_q;
		a_d        = a_q;
		m_d        = m_q;
		b_d        = b_q;
		x_d        = x_q;
		y_d        = y_q;
		res_val_d  = res_val_q;
		res_st_d   = res_st_q;
		mem_we     = 1'b0;
		mem_waddr  = s_q;
		mem_wdata  = piv_q;
		mem_raddr  = lo_q;
		cmp_lhs    = a_q;
		cmp_rhs    = mem_rdata;
		item_stall = 1'b1;
		round_end  = 1'b0;
		med        = MED_LO;

		unique case (state_q)
			S_LOAD: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (!full) begin
						mem_we    = 1'b1;
						mem_waddr = cnt_q[AW-1:0];
						mem_wdata = item_value;
						cnt_d     = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (item_last) begin
						cnt_d = '0;
						ovf_d = 1'b0;
						lo_d  = '0;
						hi_d  = cnt_q[AW-1:0];
						if (ovf_q || full) begin
							res_val_d = '0;
							res_st_d  = STATUS_OVF;
							state_d   = S_DONE;
						end else if (RW'(rank) >= RW'(cnt_q) + RW'(1)) begin
							res_val_d = '0;
							res_st_d  = STATUS_RANK;
							state_d   = S_DONE;
						end else begin
							state_d = S_RD_LO;
						end
					end
				end
			end
			S_RD_LO: begin
				mem_raddr = lo_q;
				state_d   = S_RD_MID;
			end
			S_RD_MID: begin
				mem_raddr = mid;
				a_d       = mem_rdata;
				state_d   = S_RD_HI;
			end
			S_RD_HI: begin
				mem_raddr = hi_q;
				m_d       = mem_rdata;
				cmp_lhs   = a_q;
				cmp_rhs   = mem_rdata;
				x_d       = cmp_gt;
				state_d   = S_MED1;
			end
			S_MED1: begin
				b_d     = mem_rdata;
				cmp_lhs = a_q;
				cmp_rhs = mem_rdata;
				y_d     = cmp_gt;
				state_d = S_MED2;
			end
			S_MED2: begin
				// The first element is the median when it lies between the other two;
				// otherwise the median is the nearer of the middle and last elements.
				cmp_lhs = m_q;
				cmp_rhs = b_q;
				if (x_q != y_q) begin
					med = MED_LO;
				end else if (x_q) begin
					med = cmp_gt ? MED_MID : MED_HI;
				end else begin
					med = cmp_gt ? MED_HI : MED_MID;
				end
				mem_wdata = a_q;
				case (med)
					MED_MID: begin
						piv_d     = m_q;
						mem_we    = 1'b1;
						mem_waddr = mid;
					end
					MED_HI: begin
						piv_d     = b_q;
						mem_we    = 1'b1;
						mem_waddr = hi_q;
					end
					default: begin
						piv_d = a_q;
					end
				endcase
				s_d     = lo_q;
				e_d     = hi_q;
				state_d = S_PART;
			end
			S_PART: begin
				mem_raddr = e_q;
				state_d   = S_SCAN_E;
			end
			S_SCAN_E: begin
				// Walk the right end down past elements not below the pivot.
				cmp_lhs = piv_q;
				cmp_rhs = mem_rdata;
				if ((s_q < e_q) && !cmp_gt) begin
					e_d       = e_q - AW'(1);
					mem_raddr = e_q - AW'(1);
				end else if (s_q < e_q) begin
					mem_we    = 1'b1;
					mem_waddr = s_q;
					mem_wdata = mem_rdata;
					s_d       = s_q + AW'(1);
					mem_raddr = s_q + AW'(1);
					state_d   = S_SCAN_S;
				end else begin
					round_end = 1'b1;
				end
			end
			S_SCAN_S: begin
				// Walk the left end up past elements not above the pivot.
				cmp_lhs = mem_rdata;
				cmp_rhs = piv_q;
				if ((s_q < e_q) && !cmp_gt) begin
					s_d       = s_q + AW'(1);
					mem_raddr = s_q + AW'(1);
				end else if (s_q < e_q) begin
					mem_we    = 1'b1;
					mem_waddr = e_q;
					mem_wdata = mem_rdata;
					e_d       = e_q - AW'(1);
					mem_raddr = e_q - AW'(1);
					state_d   = S_SCAN_E;
				end else begin
					round_end = 1'b1;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase

		// The pivot fills the final hole, then only the side holding the rank is kept.
		if (round_end) begin
			mem_we    = 1'b1;
			mem_waddr = s_q;
			mem_wdata = piv_q;
			if (SW'(s_q) == SW'(rank)) begin
				res_val_d = piv_q;
				res_st_d  = STATUS_OK;
				state_d   = S_DONE;
			end else if (SW'(s_q) > SW'(rank)) begin
				hi_d    = s_q - AW'(1);
				state_d = S_RD_LO;
			end else begin
				lo_d    = s_q + AW'(1);
				state_d = S_RD_LO;
			end
		end
	end

endmodule

// ===== rtl/core/kth_smallest_select.sv =====
// Rank selection over a loaded data set. Signed 32-bit values arrive one per beat on the
// item channel, and the beat with last set closes the set. The block then returns the
// element of zero-based rank target_rank in ascending order as one beat on the result
// channel, along with a status: ok, rank not below the loaded count (value zero), or
// store overflow (value zero), the last meaning more than MAX_ITEMS beats came in and the
// excess was dropped. Loading runs at one beat per cycle. Selection is quickselect with a
// median-of-three pivot and in-place hole-filling partitions, all sequenced through one
// single-port-read memory and one shared signed comparator; each round reads the first,
// middle and last elements of its range, takes their median as pivot and then scans the
// range from both ends toward each other. The item channel stalls from the closing
// beat until the result is handed to the output register, while a finished result may
// wait there as the next set loads. The target_rank register is written through the
// cfg channel, which is always ready, and must only be written while no set is being
// selected.
module kth_smallest_select import kss_pkg::*; #(
	parameter int MAX_ITEMS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [RANK_W-1:0]          cfg_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic                       last,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [VALUE_W-1:0]  selected_value,
	output logic [STATUS_W-1:0]        status
);

	localparam int AW = $clog2(MAX_ITEMS);

	logic [RANK_W-1:0]         rank_q;
	logic                      result_valid_q;
	logic signed [VALUE_W-1:0] sel_q;
	logic [STATUS_W-1:0]       status_q;
	result_t                   res;
	logic                      res_take;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic signed [VALUE_W-1:0] mem_rdata;

	// The rank register takes a write on any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= cfg_data;
		end
	end

	// The output register takes the finished result whenever it is empty or its
	// beat is being taken in this cycle.
	assign res_take = res.valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			sel_q    <= res.value;
			status_q <= res.status;
		end
	end

	assign result_valid   = result_valid_q;
	assign selected_value = sel_q;
	assign status         = status_q;

	// Element store, one entry per possible element of a set.
	kss_mem #(
		.DEPTH (MAX_ITEMS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer for loading, pivot choice, partition scans and narrowing.
	kss_ctrl #(
		.DEPTH (MAX_ITEMS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_value (value),
		.item_last  (last),
		.item_stall (item_stall),
		.rank       (rank_q),
		.res        (res),
		.res_take   (res_take),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule

// ===== rtl/core/kss_checker.sv =====
`include "kth_smallest_select_defines.svh"

module kss_checker import kss_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_stall,
	input logic                      last,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic signed [VALUE_W-1:0] selected_value,
	input logic [STATUS_W-1:0]       status
);

	// A closing beat ends loading, so the item channel must stall next cycle.
	`KSS_ASSERT_NEXT(a_last_stalls, item_valid && !item_stall && last, item_stall, "no stall after last beat")

	// A new result only appears straight after items were held off.
	`KSS_ASSERT_SAME(a_result_after_stall, $rose(result_valid), $past(item_stall), "result without stall")

	// Any status other than ok carries a zero value.
	`KSS_ASSERT_SAME(a_error_zero, result_valid && (status != STATUS_OK), selected_value == '0, "nonzero value on error")

	// A stalled result beat holds its payload.
	`KSS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(selected_value) && $stable(status), "result changed under stall")

endmodule

bind kth_smallest_select kss_checker u_kss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.last           (last),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.selected_value (selected_value),
	.status         (status)
);

// ===== verif/kth_smallest_select_checker.sv =====
module kth_smallest_select_checker import kss_pkg::*; #(
	parameter int MAX_ITEMS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [RANK_W-1:0]          cfg_data,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic                       last,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic signed [VALUE_W-1:0]  selected_value,
	input  logic [STATUS_W-1:0]        status,
	output int                         fail_count,
	output int                         outstanding
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
	} rank_result_t;

	rank_result_t              due_results[$];
	logic signed [VALUE_W-1:0] set_mem [0:MAX_ITEMS-1];
	int                        set_count = 0;
	bit                        set_overflow = 1'b0;
	logic [RANK_W-1:0]         rank_reg = '0;

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	function automatic void swap_entries(input int i, input int j);
		logic signed [VALUE_W-1:0] t;
		t = set_mem[i];
		set_mem[i] = set_mem[j];
		set_mem[j] = t;
	endfunction

	// Quickselect with a median-of-three pivot and hole-filling partitions, narrowing
	// only the side that holds the rank.
	function automatic logic signed [VALUE_W-1:0] pick_rank(input int n, input int r);
		int lo;
		int hi;
		int s;
		int e;
		int mid;
		logic signed [VALUE_W-1:0] piv;
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			s = lo;
			e = hi;
			mid = lo + ((hi - lo) >> 1);
			if (set_mem[lo] > set_mem[hi])
				swap_entries(lo, hi);
			if (set_mem[mid] > set_mem[hi])
				swap_entries(mid, hi);
			if (set_mem[lo] < set_mem[mid])
				swap_entries(mid, lo);
			piv = set_mem[s];
			while (s < e) begin
				while (s < e && set_mem[e] >= piv)
					e--;
				set_mem[s] = set_mem[e];
				while (s < e && set_mem[s] <= piv)
					s++;
				set_mem[e] = set_mem[s];
			end
			set_mem[s] = piv;
			if (s == r)
				return piv;
			if (s > r)
				hi = s - 1;
			else
				lo = s + 1;
		end
		return '0;
	endfunction

	always @(posedge clk) begin : watch
		rank_result_t got;
		rank_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				rank_reg = cfg_data;

			// Results first: a result can never belong to a set closed on the same edge.
			if (result_valid && !result_stall) begin
				got.value = selected_value;
				got.status = status;
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat, expected none, got value %0d status %0d",
						$time, got.value, got.status);
				end else begin
					want = due_results.pop_front();
					if (got.value !== want.value) begin
						fail_count++;
						$display("%0t: selected_value expected %0d, got %0d",
							$time, want.value, got.value);
					end
					if (got.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, got.status);
					end
				end
			end

			if (item_valid && !item_stall) begin
				if (set_count < MAX_ITEMS) begin
					set_mem[set_count] = value;
					set_count++;
				end else begin
					set_overflow = 1'b1;
				end
				if (last) begin
					if (set_overflow) begin
						want.value = '0;
						want.status = STATUS_OVF;
					end else if (int'(rank_reg) >= set_count) begin
						want.value = '0;
						want.status = STATUS_RANK;
					end else begin
						want.value = pick_rank(set_count, int'(rank_reg));
						want.status = STATUS_OK;
					end
					due_results.push_back(want);
					set_count = 0;
					set_overflow = 1'b0;
				end
			end

			outstanding <= due_results.size();
		end
	end

endmodule

// ===== verif/kth_smallest_select_tb.sv =====
// Top of the selection testbench. It makes the stimulus, owns the clock, the reset and the
// receiver's stall, and gives the verdict. All prediction and comparison happens in the
// checker instantiated beside the block, which hands back its failure count and the
// number of results still owed.
module kth_smallest_select_tb;
	import kss_pkg::*;

	localparam int MAX_ITEMS = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VMAX = ~VMIN;
	// Length of the long receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 400;

	// Shapes of generated data sets. Narrow sets are full of equal values, which
	// exercise the equality paths of the partition scans; the corner shape draws
	// only from the extremes of the signed range, zero and minus one.
	typedef enum {
		SHAPE_SPREAD,
		SHAPE_NARROW,
		SHAPE_RISING,
		SHAPE_FALLING,
		SHAPE_CORNERS
	} set_shape_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [RANK_W-1:0]          cfg_data = '0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       last = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [VALUE_W-1:0]  selected_value;
	logic [STATUS_W-1:0]        status;

	int fail_count;
	int outstanding;

	// Idle and stall rates in percent, changed from phase to phase by the stimulus.
	int send_idle_pct = 0;
	int stall_pct = 0;

	// The stimulus raises hold_go for one cycle; the receiver process then counts
	// the hold-off down on its own.
	logic hold_go = 1'b0;
	int   hold_left = 0;

	int cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	kth_smallest_select #(
		.MAX_ITEMS(MAX_ITEMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.selected_value(selected_value),
		.status(status)
	);

	kth_smallest_select_checker #(
		.MAX_ITEMS(MAX_ITEMS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.selected_value(selected_value),
		.status(status),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// Receiver side. During a hold-off it stalls every cycle so that a finished result
	// sits in the output register, the next set closes behind it and the item channel
	// backs up. Otherwise it stalls at the rate of the current phase.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a hung handshake or a result that never comes ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Writes the target rank. Only called while the block holds no set.
	task automatic write_rank(input logic [RANK_W-1:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Offers one beat and returns in the time step of its acceptance. Valid is left high,
	// so the caller must either offer the next beat or quiet the channel right away.
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
		while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_set(input int size, input set_shape_t shape);
		logic signed [VALUE_W-1:0] v;
		int base;
		base = $urandom;
		for (int i = 0; i < size; i++) begin
			case (shape)
			SHAPE_SPREAD: v = $urandom;
			SHAPE_NARROW: v = $urandom_range(6) - 3;
			SHAPE_RISING: v = base + i * 3;
			SHAPE_FALLING: v = base - i * 3;
			default: begin
				case ($urandom_range(3))
				0: v = VMIN;
				1: v = VMAX;
				2: v = '0;
				default: v = -1;
				endcase
			end
			endcase
			send_item(v, i == size - 1);
		end
	endtask

	// Drops valid, waits until every owed result has come back and then lets the clock run on
	// so the block is surely idle before the rank register changes.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. Rank 0 picks the minimum out of the corner values.
		write_rank(0);
		send_item(VMAX, 1'b0);
		send_item('0, 1'b0);
		send_item(VMIN, 1'b0);
		send_item(-1, 1'b0);
		send_item(1, 1'b1);

		// Rank at count minus one with duplicates in the set: the maximum comes back.
		settle();
		write_rank(4);
		send_item(VMIN, 1'b0);
		send_item(5, 1'b0);
		send_item(VMAX, 1'b0);
		send_item(5, 1'b0);
		send_item(-7, 1'b1);

		// A rank equal to the count is out of range for a pair, and a rank above the count for a single beat.
		settle();
		write_rank(2);
		send_item(9, 1'b0);
		send_item(-9, 1'b1);
		send_item(32'sh5a5a_5a5a, 1'b1);

		// Highest rank, out of range for a short set.
		settle();
		write_rank(4095);
		send_item(3, 1'b0);
		send_item(2, 1'b0);
		send_item(1, 1'b1);

		// Rank 0 over values next to the extremes of the signed range.
		settle();
		write_rank(0);
		send_item(-2, 1'b0);
		send_item(VMIN + 1, 1'b0);
		send_item(VMAX - 1, 1'b1);

		// Random part. Each idling mode gets a few rank settings and a handful of short
		// sets of mixed shapes; ranks stay low so most sets select successfully.
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 77;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 77;
			end
			default: begin
				send_idle_pct = 27;
				stall_pct = 27;
			end
			endcase
			for (int sub = 0; sub < 3; sub++) begin
				settle();
				write_rank(sub == 0 ? RANK_W'($urandom_range(3)) : RANK_W'($urandom_range(12)));
				for (int k = 0; k < 6; k++)
					send_set($urandom_range(1, 18), set_shape_t'($urandom_range(4)));
			end
		end

		// Back pressure: the receiver holds off for a long stretch while several sets are
		// offered, so the output register fills and the item channel stalls.
		send_idle_pct = 0;
		stall_pct = 0;
		settle();
		write_rank(2);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		for (int k = 0; k < 6; k++)
			send_set($urandom_range(3, 10), set_shape_t'($urandom_range(4)));

		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/kss_pkg.sv
rtl/core/kss_mem.sv
rtl/core/kss_cmp.sv
rtl/core/kss_ctrl.sv
rtl/core/kth_smallest_select.sv
rtl/core/kss_checker.sv
verif/kth_smallest_select_checker.sv
verif/kth_smallest_select_tb.sv
